/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fir_pkg.sv */
// ----------------------------------------------------------------------------
// fir_pkg
// Types and fixed constants of the saturating FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  // Request field widths fixed by the interface.
  localparam int COEF_INDEX_W = 6;

  // Configuration registers.
  localparam int TAP_COUNT_W  = 7;
  localparam int SHIFT_W      = 5;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = 1;
  localparam int PDATA_W      = 32;

  localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT    = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SHIFT = 1'b1;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST    = 7'd25;
  localparam logic [SHIFT_W-1:0]     OUTPUT_SHIFT_RST = 5'd15;

  // Request function codes.
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SHIFT,
    ST_OUT
  } fir_state_t;

endpackage

/* hdl/fir_if.sv */
// ----------------------------------------------------------------------------
// fir_if
// Valid/ready channels carrying filter requests and filter results.
// ----------------------------------------------------------------------------
interface fir_in_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
);
  import fir_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           func;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [COEF_INDEX_W-1:0]        coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;
  logic                           block_end;

  modport source (output valid, func, sample, coef_index, coef_value, block_end,
                  input ready);
  modport sink   (input valid, func, sample, coef_index, coef_value, block_end,
                  output ready);
endinterface

interface fir_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
  logic                           saturated;
  logic                           block_end_out;

  modport source (output valid, filtered_sample, saturated, block_end_out,
                  input ready);
  modport sink   (input valid, filtered_sample, saturated, block_end_out,
                  output ready);
endinterface

/* hdl/fir_filter_saturating_core.sv */
// ----------------------------------------------------------------------------
// fir_filter_saturating_core
// Direct-form FIR filter with one shared multiply-accumulate and saturation.
// ----------------------------------------------------------------------------
// A filter request (func = FUNC_FILTER) yields one result: the sum of
// coefficient[k] * x[n-k] over the active taps, arithmetically shifted right
// by output_shift and clamped to the signed sample range, with a flag when
// clamping happened. A coefficient request (func = FUNC_COEF) writes one
// coefficient and yields no result. One multiplier and one accumulator walk
// the taps, one tap per cycle, reading the coefficient and history memories
// through registered read ports; a filter request therefore occupies the
// block through the accepting step, the tap issues, the pipeline drain, a
// shift step and an output step, longer only while an earlier result still
// waits in the output register. The tap walk is what sets the rate. A
// finished result waits in the output register, so the next request is taken
// while the previous result is still pending. Both memories read as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
// Registers: tap_count at byte address 0, output_shift at 4; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir_filter_saturating_core #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int ACC_WIDTH    = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fir_in_if.sink                        in_ch,
  fir_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fir_pkg::PADDR_W-1:0]   paddr,
  input  logic [fir_pkg::PDATA_W-1:0]   pwdata,
  output logic [fir_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import fir_pkg::*;

  localparam int HIST_DEPTH = MAX_TAPS - 1;
  localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int TAP_W      = $clog2(MAX_TAPS);
  localparam int CNT_W      = $clog2(MAX_TAPS + 1);
  localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;

  // Configuration registers.
  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic [SHIFT_W-1:0]     output_shift_r;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   reg_idx;

  // Sequencer.
  fir_state_t state_r, state_nxt;
  logic       in_acc, filt_acc, coef_acc;
  logic       issue, last_issue, load_out;

  // Request latched for the tap walk.
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           blk_r;
  logic [CNT_W-1:0]               taps_r, taps_eff;
  logic [CNT_W-1:0]               k_r;
  logic [PTR_W-1:0]               rptr_r;
  logic [PTR_W-1:0]               hptr_r;

  // Memories with their valid bits.
  logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
  logic                           coef_vld_r [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_mem [HIST_DEPTH];
  logic                           hist_vld_r [HIST_DEPTH];
  logic                           coef_wr;
  logic [TAP_W-1:0]               coef_waddr;

  // MAC pipeline.
  logic                           rd_v_r, rd_selx_r;
  logic signed [COEF_WIDTH-1:0]   coef_rd_r;
  logic                           coef_ok_r;
  logic signed [SAMPLE_WIDTH-1:0] hist_rd_r;
  logic                           hist_ok_r;
  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic                           mul_v_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_WIDTH-1:0]    acc_r;
  logic signed [ACC_WIDTH-1:0]    shifted_r;

  // Saturation and result register.
  logic [ACC_WIDTH-SAMPLE_WIDTH:0] upper;
  logic                            fits;
  logic signed [SAMPLE_WIDTH-1:0]  sat_val;
  logic                            out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0]  out_sample_r;
  logic                            out_sat_r;
  logic                            out_blk_r;

  // --------------------------------------------------------------------------
  // Configuration port: two-phase write, always ready, byte address 4*index.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r    <= TAP_COUNT_RST;
      output_shift_r <= OUTPUT_SHIFT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TAP_COUNT:    tap_count_r    <= pwdata[TAP_COUNT_W-1:0];
        REG_OUTPUT_SHIFT: output_shift_r <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TAP_COUNT:    prdata = {{(PDATA_W-TAP_COUNT_W){1'b0}}, tap_count_r};
      REG_OUTPUT_SHIFT: prdata = {{(PDATA_W-SHIFT_W){1'b0}}, output_shift_r};
      default:          prdata = '0;
    endcase
  end

  // Clamp the tap count: zero means one tap, anything above the store depth
  // means the full depth.
  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = CNT_W'(1);
    end else if (32'(tap_count_r) > 32'(MAX_TAPS)) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(tap_count_r);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign filt_acc    = in_acc && (in_ch.func == FUNC_FILTER);
  assign coef_acc    = in_acc && (in_ch.func == FUNC_COEF);
  assign last_issue  = (k_r == taps_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (filt_acc) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        issue = 1'b1;
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!rd_v_r && !mul_v_r) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tap walk: coefficient k pairs with the new sample for k = 0, and with
  // history slot (pointer - k) mod depth otherwise.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (filt_acc) begin
      x_r    <= in_ch.sample;
      blk_r  <= in_ch.block_end;
      taps_r <= taps_eff;
      rptr_r <= hptr_r;
    end else if (issue) begin
      rptr_r <= (rptr_r == '0) ? PTR_W'(HIST_DEPTH - 1) : rptr_r - PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      if (filt_acc) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + CNT_W'(1);
      end
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
    end
  end

  // Coefficient store: write on a coefficient request, read during the walk.
  assign coef_waddr = TAP_W'(in_ch.coef_index);
  assign coef_wr    = coef_acc && (32'(in_ch.coef_index) < 32'(MAX_TAPS));

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_waddr] <= in_ch.coef_value;
    end
    coef_rd_r <= coef_mem[k_r[TAP_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) coef_vld_r[i] <= 1'b0;
    end else if (coef_wr) begin
      coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  // History: write the new sample once its result is out, read during the walk.
  always_ff @(posedge clk) begin
    if (load_out) begin
      hist_mem[hptr_r] <= x_r;
    end
    hist_rd_r <= hist_mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_vld_r[i] <= 1'b0;
      hptr_r <= '0;
    end else if (load_out) begin
      hist_vld_r[hptr_r] <= 1'b1;
      hptr_r <= (32'(hptr_r) == HIST_DEPTH - 1) ? '0 : hptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    coef_ok_r <= coef_vld_r[k_r[TAP_W-1:0]];
    hist_ok_r <= hist_vld_r[rptr_r];
    rd_selx_r <= (k_r == '0);
  end

  // Shared multiplier, then accumulate with two's complement wrap.
  assign mul_a = coef_ok_r ? coef_rd_r : '0;
  assign mul_b = rd_selx_r ? x_r : (hist_ok_r ? hist_rd_r : '0);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (filt_acc) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + ACC_WIDTH'(prod_r);
    end
    if (state_r == ST_SHIFT) begin
      shifted_r <= acc_r >>> output_shift_r;
    end
  end

  // --------------------------------------------------------------------------
  // Saturation and result register
  // --------------------------------------------------------------------------
  assign upper = shifted_r[ACC_WIDTH-1:SAMPLE_WIDTH-1];
  assign fits  = (&upper) || !(|upper);

  always_comb begin
    if (fits) begin
      sat_val = shifted_r[SAMPLE_WIDTH-1:0];
    end else if (shifted_r[ACC_WIDTH-1]) begin
      sat_val = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= sat_val;
      out_sat_r    <= !fits;
      out_blk_r    <= blk_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.filtered_sample = out_sample_r;
  assign out_ch.saturated       = out_sat_r;
  assign out_ch.block_end_out   = out_blk_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_filt_starts_walk, clk, rst_n, filt_acc, state_r == ST_RUN, "filter request did not start the tap walk")
  `ASSERT_NEXT(a_coef_keeps_ptr, clk, rst_n, coef_acc, $stable(hptr_r), "coefficient request moved the history pointer")
  `ASSERT_NOW(a_walk_in_range, clk, rst_n, state_r == ST_RUN, k_r < taps_r, "tap counter ran past the tap count")
  `ASSERT_NOW(a_ptr_in_range, clk, rst_n, 1'b1, 32'(hptr_r) < HIST_DEPTH, "history pointer out of range")
  `ASSERT_NOW(a_result_from_out, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT, "result appeared outside the output step")

endmodule
